>>> src/biquad_highpass_filter_top_macros.svh
// Assertion macros for the biquad highpass filter.
`ifndef BIQUAD_HIGHPASS_FILTER_TOP_MACROS_SVH
`define BIQUAD_HIGHPASS_FILTER_TOP_MACROS_SVH
`ifndef SYNTH
`define BHF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bhf assertion failed");
`define BHF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bhf assertion failed");
`else
`define BHF_ASSERT_IMPL(lbl, ante, cons)
`define BHF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> src/bhf_pkg.sv
// Shared constants, types and tables of the biquad highpass filter.
package bhf_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int CORDIC_STEPS     = 16;
    localparam int XW               = 33;   // CORDIC vector width, Q2.30 plus headroom
    localparam int DVD_W            = 61;   // divider dividend and quotient width
    localparam int DVS_W            = 39;   // divider divisor width
    localparam int AW               = 40;   // coefficient multiplicand width
    localparam int IW               = 31;   // reciprocal width
    localparam int PW               = 72;   // coefficient product width

    localparam logic signed [XW-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [XW-1:0] ONE30       = 33'sd1073741824;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_CORD = 10'b0000000010,
        S_DIV1 = 10'b0000000100,
        S_DIV2 = 10'b0000001000,
        S_MUL  = 10'b0000010000,
        S_FA   = 10'b0000100000,
        S_FB   = 10'b0001000000,
        S_FC   = 10'b0010000000,
        S_FD   = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    // Arctangent of 2^-i in units of 2^32 per turn.
    function automatic logic [29:0] atan_turn(input logic [3:0] idx);
        logic [29:0] v;
        case (idx)
            4'd0:    v = 30'd536870912;
            4'd1:    v = 30'd316933406;
            4'd2:    v = 30'd167458907;
            4'd3:    v = 30'd85004757;
            4'd4:    v = 30'd42667331;
            4'd5:    v = 30'd21354465;
            4'd6:    v = 30'd10679838;
            4'd7:    v = 30'd5340245;
            4'd8:    v = 30'd2670163;
            4'd9:    v = 30'd1335087;
            4'd10:   v = 30'd667544;
            4'd11:   v = 30'd333772;
            4'd12:   v = 30'd166886;
            4'd13:   v = 30'd83443;
            4'd14:   v = 30'd41722;
            4'd15:   v = 30'd20861;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

>>> src/bhf_if.sv
// Valid/ready channel interfaces for filter input and output beats.
interface bhf_in_if;
    logic               valid;
    logic               ready;
    logic        [2:0]  channel;
    logic signed [15:0] sample_in;
    logic        [15:0] cutoff;
    logic        [15:0] resonance;

    modport source (output valid, channel, sample_in, cutoff, resonance, input ready);
    modport sink   (input valid, channel, sample_in, cutoff, resonance, output ready);
endinterface

interface bhf_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;
    logic        [2:0]  channel_out;
    logic               saturated;

    modport source (output valid, sample_out, channel_out, saturated, input ready);
    modport sink   (input valid, sample_out, channel_out, saturated, output ready);
endinterface

>>> src/bhf_cordic.sv
// Iterative CORDIC producing clamped sin and cos of the cutoff angle.
module bhf_cordic (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [14:0]                 i_phase,
    input  logic                        i_neg,
    output logic                        o_done,
    output logic signed [bhf_pkg::XW-1:0] o_sin,
    output logic signed [bhf_pkg::XW-1:0] o_cos
);
    import bhf_pkg::*;

    logic signed [XW-1:0] r_x, r_y, r_z, n_x, n_y, n_z;
    logic signed [XW-1:0] dx, dy, at, cneg;
    logic [3:0]           r_i;
    logic                 r_busy, r_done, r_neg;

    always_comb begin
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        at = signed'({3'b000, atan_turn(r_i)});
        if (!r_z[XW-1]) begin
            n_x = r_x - dx;
            n_y = r_y + dy;
            n_z = r_z - at;
        end else begin
            n_x = r_x + dx;
            n_y = r_y - dy;
            n_z = r_z + at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                r_i <= r_i + 4'd1;
                if (r_i == 4'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= CORDIC_GAIN;
            r_y   <= '0;
            r_z   <= signed'({2'b00, i_phase, 16'h0000});
            r_neg <= i_neg;
        end else if (r_busy) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    always_comb begin
        cneg = r_neg ? -r_x : r_x;
        if (r_y[XW-1])      o_sin = '0;
        else if (r_y > ONE30) o_sin = ONE30;
        else                o_sin = r_y;
        if (cneg > ONE30)       o_cos = ONE30;
        else if (cneg < -ONE30) o_cos = -ONE30;
        else                    o_cos = cneg;
    end

    assign o_done = r_done;
endmodule

>>> src/bhf_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module bhf_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bhf_pkg::DVD_W-1:0]  i_dividend,
    input  logic [bhf_pkg::DVS_W-1:0]  i_divisor,
    output logic                       o_done,
    output logic [bhf_pkg::DVD_W-1:0]  o_quot
);
    import bhf_pkg::*;

    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_rem, r_dvs;
    logic [DVS_W:0]   trial;
    logic             take;
    logic [5:0]       r_cnt;
    logic             r_busy, r_done;

    assign trial = {r_rem, r_dvd[DVD_W-1]};
    assign take  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out at the top while quotient bits shift in below.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], take};
            r_rem <= take ? DVS_W'(trial - {1'b0, r_dvs}) : trial[DVS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;
endmodule

>>> src/bhf_cmul.sv
// Shift-add multiplier forming the three Q2.14 coefficients from the reciprocal.
module bhf_cmul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [bhf_pkg::AW-1:0] i_a0,
    input  logic signed [bhf_pkg::AW-1:0] i_a1,
    input  logic signed [bhf_pkg::AW-1:0] i_a2,
    input  logic        [bhf_pkg::IW-1:0] i_b,
    output logic                          o_done,
    output logic signed [15:0]            o_g,
    output logic signed [15:0]            o_f1,
    output logic signed [15:0]            o_f2
);
    import bhf_pkg::*;

    logic signed [PW-1:0] r_s0, r_s1, r_s2, r_p0, r_p1, r_p2;
    logic        [IW-1:0] r_b;
    logic        [4:0]    r_cnt;
    logic                 r_busy, r_done;

    // Shift right by 46 rounding half away from zero, then saturate to 16 bits.
    function automatic logic signed [15:0] rnd46(input logic signed [PW-1:0] v);
        logic [PW-1:0] m;
        logic [PW-1:0] s;
        logic [25:0]   m2;
        logic          neg;
        neg = v[PW-1];
        m   = neg ? PW'(-v) : PW'(v);
        s   = (m + (PW'(1) << 45)) >> 46;
        m2  = s[25:0];
        if (!neg && m2 > 26'd32767)     return 16'sh7fff;
        else if (neg && m2 > 26'd32768) return 16'sh8000;
        else if (neg)                   return 16'(-m2);
        else                            return 16'(m2);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(IW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_s0 <= PW'(i_a0);
            r_s1 <= PW'(i_a1);
            r_s2 <= PW'(i_a2);
            r_p0 <= '0;
            r_p1 <= '0;
            r_p2 <= '0;
            r_b  <= i_b;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_p0 <= r_p0 + r_s0;
                r_p1 <= r_p1 + r_s1;
                r_p2 <= r_p2 + r_s2;
            end
            r_s0 <= r_s0 <<< 1;
            r_s1 <= r_s1 <<< 1;
            r_s2 <= r_s2 <<< 1;
            r_b  <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_g    = rnd46(r_p0);
    assign o_f1   = rnd46(r_p1);
    assign o_f2   = rnd46(r_p2);
endmodule

>>> src/biquad_highpass_filter_top.sv
// Top level of the multichannel biquad highpass filter.
// Input beats on i_in carry a channel, a signed 16-bit sample, a cutoff
// (cycles per sample times 65536, clamped to one half) and a Q in Q8.8.
// Each beat yields one output beat on o_out with the filtered sample, the
// input channel field and a flag that marks a clipped result.
// One item is processed at a time: a new input beat is not taken until
// the current result is registered. Each item passes through 16 CORDIC
// steps, two bit-serial divisions, 31 shift-add steps and the filter
// states; i_in is ready again in the cycle after the result is registered.
// A finished result waits in the output register, so a new input beat is
// taken while the receiver stalls; the next result is held back until the
// waiting one has been taken.
// Synchronous reset clears the per-channel history to zero through valid
// bits, so no clearing pass is needed; i_in is ready right after reset.
module biquad_highpass_filter_top #(
    parameter int NUM_CHANNELS = bhf_pkg::NUM_CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bhf_in_if.sink      i_in,
    bhf_out_if.source   o_out
);
    import bhf_pkg::*;
    `include "biquad_highpass_filter_top_macros.svh"

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    t_state r_state;

    logic               in_acc;
    logic [CH_W-1:0]    idx, r_idx;
    logic [2:0]         r_ch;
    logic signed [15:0] r_x;
    logic [15:0]        r_res;
    logic [15:0]        p_clamp, t_full;
    logic               neg_cos;

    logic [63:0]        r_mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_valid;
    logic [63:0]        r_rd, hist, wr_word;
    logic               r_hv, wr_en;
    logic signed [15:0] x1, x2, y1, y2;

    logic               cord_done, div_start, div_done, mul_start, mul_done;
    logic signed [XW-1:0] sin30, cos30;
    logic [DVD_W-1:0]   div_dvd, quot;
    logic [DVS_W-1:0]   div_dvs, a0;
    logic [37:0]        r_alpha;
    logic signed [AW-1:0] ma0, ma1, ma2;
    logic signed [15:0] cg, cf1, cf2, r_g, r_f1, r_f2;

    logic signed [17:0] d_in, mop_a;
    logic signed [16:0] mop_b;
    logic signed [34:0] r_prod;
    logic signed [39:0] r_acc;

    logic [39:0]        am, as;
    logic [24:0]        am2;
    logic               aneg, sat;
    logic signed [15:0] y;

    logic               r_ovld, out_free;
    logic signed [15:0] r_osmp;
    logic [2:0]         r_och;
    logic               r_osat;

    assign in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // The channel field has eight values, so the history index is a small table.
    always_comb begin
        idx = '0;
        for (int k = 0; k < 8; k++) begin
            if (i_in.channel == 3'(k)) idx = CH_W'(k % NUM_CHANNELS);
        end
    end

    assign p_clamp  = (i_in.cutoff > 16'd32768) ? 16'd32768 : i_in.cutoff;
    assign neg_cos  = (p_clamp > 16'd16384);
    assign t_full   = neg_cos ? (16'd32768 - p_clamp) : p_clamp;

    // History word: {x1, x2, y1, y2}; a channel never written reads as zero.
    assign hist = r_hv ? r_rd : 64'h0;
    assign x1   = hist[63:48];
    assign x2   = hist[47:32];
    assign y1   = hist[31:16];
    assign y2   = hist[15:0];

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_idx] <= wr_word;
        if (in_acc) r_rd <= r_mem[idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_hv    <= 1'b0;
        end else begin
            if (wr_en) r_valid[r_idx] <= 1'b1;
            if (in_acc) r_hv <= r_valid[idx];
        end
    end

    bhf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_phase (t_full[14:0]),
        .i_neg   (neg_cos),
        .o_done  (cord_done),
        .o_sin   (sin30),
        .o_cos   (cos30)
    );

    // One divider serves alpha = sin*128/Q and the reciprocal of 1 + alpha.
    assign a0        = DVS_W'(ONE30) + {1'b0, quot[37:0]};
    assign div_start = ((r_state == S_CORD) && cord_done) ||
                       ((r_state == S_DIV1) && div_done);
    always_comb begin
        if (r_state == S_CORD) begin
            div_dvd = {23'd0, sin30[30:0], 7'd0};
            div_dvs = {23'd0, (r_res == 16'd0) ? 16'd1 : r_res};
        end else begin
            div_dvd = {1'b1, 60'd0} + {23'd0, a0[38:1]};
            div_dvs = a0;
        end
    end

    bhf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    assign mul_start = (r_state == S_DIV2) && div_done;
    assign ma0 = AW'(ONE30) + AW'(cos30);
    assign ma1 = AW'(cos30) <<< 1;
    assign ma2 = AW'(ONE30) - signed'({2'b00, r_alpha});

    bhf_cmul u_cmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a0    (ma0),
        .i_a1    (ma1),
        .i_a2    (ma2),
        .i_b     (quot[IW-1:0]),
        .o_done  (mul_done),
        .o_g     (cg),
        .o_f1    (cf1),
        .o_f2    (cf2)
    );

    // Filter multiply operands, one product per cycle.
    assign d_in = 18'(r_x) + 18'(x2) - (18'(x1) <<< 1);
    always_comb begin
        case (r_state)
            S_FA: begin
                mop_a = d_in;
                mop_b = 17'(r_g);
            end
            S_FB: begin
                mop_a = 18'(y1);
                mop_b = 17'(r_f1) <<< 1;
            end
            default: begin
                mop_a = 18'(y2);
                mop_b = 17'(r_f2) <<< 1;
            end
        endcase
    end

    // Output rounding: shift right by 15, half away from zero, then saturate.
    always_comb begin
        aneg = r_acc[39];
        am   = aneg ? 40'(-r_acc) : 40'(r_acc);
        as   = (am + 40'd16384) >> 15;
        am2  = as[24:0];
        sat  = (!aneg && am2 > 25'd32767) || (aneg && am2 > 25'd32768);
        if (sat)       y = aneg ? 16'sh8000 : 16'sh7fff;
        else if (aneg) y = 16'(-am2);
        else           y = 16'(am2);
    end

    assign out_free = !r_ovld || o_out.ready;
    assign wr_en    = (r_state == S_OUT) && out_free;
    assign wr_word  = {r_x, x1, y, y1};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            if (r_ovld && o_out.ready) r_ovld <= 1'b0;
            case (r_state)
                S_IDLE: if (in_acc) r_state <= S_CORD;
                S_CORD: if (cord_done) r_state <= S_DIV1;
                S_DIV1: if (div_done) r_state <= S_DIV2;
                S_DIV2: if (div_done) r_state <= S_MUL;
                S_MUL:  if (mul_done) r_state <= S_FA;
                S_FA:   r_state <= S_FB;
                S_FB:   r_state <= S_FC;
                S_FC:   r_state <= S_FD;
                S_FD:   r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_ovld  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ch  <= i_in.channel;
            r_idx <= idx;
            r_x   <= i_in.sample_in;
            r_res <= i_in.resonance;
        end
        if ((r_state == S_DIV1) && div_done) r_alpha <= quot[37:0];
        if ((r_state == S_MUL) && mul_done) begin
            r_g  <= cg;
            r_f1 <= cf1;
            r_f2 <= cf2;
        end
        r_prod <= mop_a * mop_b;
        case (r_state)
            S_FB:    r_acc <= 40'(r_prod);
            S_FC:    r_acc <= r_acc + 40'(r_prod);
            S_FD:    r_acc <= r_acc - 40'(r_prod);
            default: r_acc <= r_acc;
        endcase
        if (wr_en) begin
            r_osmp <= y;
            r_och  <= r_ch;
            r_osat <= sat;
        end
    end

    assign o_out.valid       = r_ovld;
    assign o_out.sample_out  = r_osmp;
    assign o_out.channel_out = r_och;
    assign o_out.saturated   = r_osat;

    `BHF_ASSERT_NEXT(a_acc_starts, in_acc, r_state == S_CORD)
    `BHF_ASSERT_IMPL(a_cord_done, cord_done, r_state == S_CORD)
    `BHF_ASSERT_IMPL(a_div_done, div_done, (r_state == S_DIV1) || (r_state == S_DIV2))
    `BHF_ASSERT_IMPL(a_mul_done, mul_done, r_state == S_MUL)
endmodule
